// ===== design/periodic_tricubic_upsampler_top_defines.svh =====
// Assertion helpers for the RTL
`ifndef PERIODIC_TRICUBIC_UPSAMPLER_TOP_DEFINES_SVH
`define PERIODIC_TRICUBIC_UPSAMPLER_TOP_DEFINES_SVH

// checked outside reset
`define PTU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define PTU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/ptu_pkg.sv =====
`default_nettype none
package ptu_pkg;

  localparam int CW     = 7;   // coordinate width
  localparam int SW     = 5;   // effective scale width (up to 15)
  localparam int WW     = 18;  // signed Q2.16 weight
  localparam int DIV_NW = 31;  // divider dividend
  localparam int DIV_DW = 14;  // divider divisor / remainder
  localparam int DIV_QW = 17;  // divider quotient
  localparam int DIV_CNTW = 5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] CFG_GRID_X = 2'd0;
  localparam logic [1:0] CFG_GRID_Y = 2'd1;
  localparam logic [1:0] CFG_GRID_Z = 2'd2;
  localparam logic [1:0] CFG_SCALE  = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DIVC_GO, S_DIVC_WT, S_NUM1, S_NUM2, S_DIVW_GO, S_DIVW_WT,
    S_RUNZ, S_GAPY, S_RUNY, S_GAPX, S_RUNX, S_DRAIN, S_DONE
  } state_e;

  typedef enum logic [1:0] {OP_Z, OP_Y, OP_X} op_e;

  typedef struct packed {
    logic       capture;
    logic       wr_req;
    logic       div_start;
    logic       div_wgt;
    logic [1:0] axis;
    logic [1:0] wk;
    logic       store_coord;
    logic       store_weight;
    logic       num1;
    logic       num2;
    logic       clr_acc;
    logic       op_valid;
    op_e        op;
    logic [1:0] q;
    logic [1:0] o;
    logic [1:0] p;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic bad_query;
    logic out_free;
  } sts_t;

  // (base - 1 + ofs) mod n, periodic neighbor index
  function automatic logic [CW-1:0] wrap_idx(input logic [CW-1:0] base,
                                             input logic [1:0] ofs,
                                             input logic [CW-1:0] n);
    logic [CW+1:0] v;
    v = {2'b0, base} + {2'b0, n} + {{CW{1'b0}}, ofs} - (CW+2)'(1);
    for (int j = 0; j < 4; j++) begin
      if (v >= {2'b0, n}) v = v - {2'b0, n};
    end
    return v[CW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/ptu_ram.sv =====
`default_nettype none
module ptu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== design/ptu_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle. Dividend must satisfy
// num >> DIV_QW < den.
module ptu_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ptu_pkg::DIV_NW-1:0]  num_i,
  input  wire logic [ptu_pkg::DIV_DW-1:0]  den_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic      [ptu_pkg::DIV_QW-1:0]  quo_o,
  output logic      [ptu_pkg::DIV_DW-1:0]  rem_o
);
  localparam int NW = ptu_pkg::DIV_NW;
  localparam int DW = ptu_pkg::DIV_DW;
  localparam int QW = ptu_pkg::DIV_QW;
  localparam int CNW = ptu_pkg::DIV_CNTW;

  logic           busy_q, busy_d, done_q, done_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]  rem_q, den_q;
  logic [QW-1:0]  quo_q;
  logic [DW:0]    trial, diff;
  logic           ge;

  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNW'(QW);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNW'(1);
      if (cnt_q == CNW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NW-1:QW];
      quo_q <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ===== design/ptu_ctrl.sv =====
`default_nettype none
`include "periodic_tricubic_upsampler_top_defines.svh"
module ptu_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          func_i,
  output logic               in_stall_o,
  output ptu_pkg::cmd_t      cmd_o,
  input  wire ptu_pkg::sts_t sts_i
);
  ptu_pkg::state_e state_q, state_d;
  logic [1:0] axis_q, axis_d, k_q, k_d, q_q, q_d, o_q, o_d, p_q, p_d;
  logic       drn_q, drn_d;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    k_d     = k_q;
    q_d     = q_q;
    o_d     = o_q;
    p_d     = p_q;
    drn_d   = drn_q;
    case (state_q)
      ptu_pkg::S_IDLE: begin
        if (in_valid_i && func_i == ptu_pkg::FUNC_QUERY) state_d = ptu_pkg::S_CHK;
      end
      ptu_pkg::S_CHK: begin
        if (sts_i.bad_query) begin
          state_d = ptu_pkg::S_DONE;
        end else begin
          axis_d  = ptu_pkg::AXIS_X;
          state_d = ptu_pkg::S_DIVC_GO;
        end
      end
      ptu_pkg::S_DIVC_GO: state_d = ptu_pkg::S_DIVC_WT;
      ptu_pkg::S_DIVC_WT: begin
        if (sts_i.div_done) state_d = ptu_pkg::S_NUM1;
      end
      ptu_pkg::S_NUM1: state_d = ptu_pkg::S_NUM2;
      ptu_pkg::S_NUM2: begin
        k_d     = 2'd0;
        state_d = ptu_pkg::S_DIVW_GO;
      end
      ptu_pkg::S_DIVW_GO: state_d = ptu_pkg::S_DIVW_WT;
      ptu_pkg::S_DIVW_WT: begin
        if (sts_i.div_done) begin
          if (k_q == 2'd3) begin
            if (axis_q == ptu_pkg::AXIS_Z) begin
              q_d     = 2'd0;
              o_d     = 2'd0;
              p_d     = 2'd0;
              state_d = ptu_pkg::S_RUNZ;
            end else begin
              axis_d  = axis_q + 2'd1;
              state_d = ptu_pkg::S_DIVC_GO;
            end
          end else begin
            k_d     = k_q + 2'd1;
            state_d = ptu_pkg::S_DIVW_GO;
          end
        end
      end
      ptu_pkg::S_RUNZ: begin
        if (q_q == 2'd3) begin
          q_d     = 2'd0;
          state_d = ptu_pkg::S_GAPY;
        end else begin
          q_d = q_q + 2'd1;
        end
      end
      ptu_pkg::S_GAPY: state_d = ptu_pkg::S_RUNY;
      ptu_pkg::S_RUNY: begin
        if (o_q == 2'd3) begin
          o_d     = 2'd0;
          state_d = ptu_pkg::S_GAPX;
        end else begin
          o_d     = o_q + 2'd1;
          state_d = ptu_pkg::S_RUNZ;
        end
      end
      ptu_pkg::S_GAPX: state_d = ptu_pkg::S_RUNX;
      ptu_pkg::S_RUNX: begin
        if (p_q == 2'd3) begin
          drn_d   = 1'b0;
          state_d = ptu_pkg::S_DRAIN;
        end else begin
          p_d     = p_q + 2'd1;
          state_d = ptu_pkg::S_RUNZ;
        end
      end
      ptu_pkg::S_DRAIN: begin
        if (drn_q) state_d = ptu_pkg::S_DONE;
        else drn_d = 1'b1;
      end
      ptu_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = ptu_pkg::S_IDLE;
      end
      default: state_d = ptu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o          = state_q != ptu_pkg::S_IDLE;
    cmd_o               = '0;
    cmd_o.capture       = state_q == ptu_pkg::S_IDLE && in_valid_i;
    cmd_o.wr_req        = cmd_o.capture && func_i == ptu_pkg::FUNC_WRITE;
    cmd_o.div_start     = state_q == ptu_pkg::S_DIVC_GO || state_q == ptu_pkg::S_DIVW_GO;
    cmd_o.div_wgt       = state_q == ptu_pkg::S_DIVW_GO;
    cmd_o.axis          = axis_q;
    cmd_o.wk            = k_q;
    cmd_o.store_coord   = state_q == ptu_pkg::S_DIVC_WT && sts_i.div_done;
    cmd_o.store_weight  = state_q == ptu_pkg::S_DIVW_WT && sts_i.div_done;
    cmd_o.num1          = state_q == ptu_pkg::S_NUM1;
    cmd_o.num2          = state_q == ptu_pkg::S_NUM2;
    cmd_o.clr_acc       = state_q == ptu_pkg::S_CHK;
    cmd_o.q             = q_q;
    cmd_o.o             = o_q;
    cmd_o.p             = p_q;
    cmd_o.load_out      = state_q == ptu_pkg::S_DONE && sts_i.out_free;
    case (state_q)
      ptu_pkg::S_RUNZ: begin
        cmd_o.op_valid = 1'b1;
        cmd_o.op       = ptu_pkg::OP_Z;
      end
      ptu_pkg::S_RUNY: begin
        cmd_o.op_valid = 1'b1;
        cmd_o.op       = ptu_pkg::OP_Y;
      end
      ptu_pkg::S_RUNX: begin
        cmd_o.op_valid = 1'b1;
        cmd_o.op       = ptu_pkg::OP_X;
      end
      default: begin
        cmd_o.op_valid = 1'b0;
        cmd_o.op       = ptu_pkg::OP_Z;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptu_pkg::S_IDLE;
      axis_q  <= '0;
      k_q     <= '0;
      q_q     <= '0;
      o_q     <= '0;
      p_q     <= '0;
      drn_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      k_q     <= k_d;
      q_q     <= q_d;
      o_q     <= o_d;
      p_q     <= p_d;
      drn_q   <= drn_d;
    end
  end

  `PTU_ASSERT(a_div_start_idle, cmd_o.div_start |-> !sts_i.div_busy, "divider restarted while busy")
  `PTU_ASSERT(a_mac_no_div, cmd_o.op_valid |-> !sts_i.div_busy, "MAC issued during weight setup")
  `PTU_ASSERT(a_stall_after_query, $rose(in_stall_o) |-> $past(in_valid_i), "stall without a transfer")
  `PTU_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !in_stall_o, "not idle after reset")
endmodule
`default_nettype wire

// ===== design/ptu_datapath.sv =====
`default_nettype none
module ptu_datapath #(
  parameter int MAX_AXIS  = 16,
  parameter int MAX_SCALE = 8,
  parameter int AXW       = 4,
  parameter int AW        = 12
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ptu_pkg::cmd_t             cmd_i,
  output ptu_pkg::sts_t                  sts_o,
  input  wire logic [ptu_pkg::CW-1:0]    coord_x_i,
  input  wire logic [ptu_pkg::CW-1:0]    coord_y_i,
  input  wire logic [ptu_pkg::CW-1:0]    coord_z_i,
  input  wire logic signed [31:0]        sample_value_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [4:0]                cfg_data_i,
  output logic                           ram_we_o,
  output logic      [AW-1:0]             ram_addr_o,
  output logic      [31:0]               ram_wdata_o,
  input  wire logic [31:0]               ram_rdata_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [31:0]             interpolated_value_o,
  output logic                           query_status_o
);
  localparam int CW = ptu_pkg::CW;
  localparam int SW = ptu_pkg::SW;
  localparam int WW = ptu_pkg::WW;

  // configuration
  logic [4:0] gsx_q, gsy_q, gsz_q;
  logic [3:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsx_q   <= 5'd16;
      gsy_q   <= 5'd16;
      gsz_q   <= 5'd16;
      scale_q <= 4'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ptu_pkg::CFG_GRID_X: gsx_q   <= cfg_data_i;
        ptu_pkg::CFG_GRID_Y: gsy_q   <= cfg_data_i;
        ptu_pkg::CFG_GRID_Z: gsz_q   <= cfg_data_i;
        ptu_pkg::CFG_SCALE:  scale_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] nx, ny, nz;
  logic [SW-1:0] s;

  function automatic logic [CW-1:0] clamp_axis(input logic [4:0] v);
    if (v == 5'd0) return CW'(1);
    if (int'(v) > MAX_AXIS) return CW'(MAX_AXIS);
    return {2'b0, v};
  endfunction

  always_comb begin
    nx = clamp_axis(gsx_q);
    ny = clamp_axis(gsy_q);
    nz = clamp_axis(gsz_q);
    if (scale_q == 4'd0) s = SW'(1);
    else if (int'(scale_q) > MAX_SCALE) s = SW'(MAX_SCALE);
    else s = {1'b0, scale_q};
  end

  // item capture and range checks
  logic [CW-1:0] cx_q, cy_q, cz_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cx_q <= coord_x_i;
      cy_q <= coord_y_i;
      cz_q <= coord_z_i;
    end
  end

  logic [11:0] bnd_x, bnd_y, bnd_z;
  logic        bad, wr_ok;
  assign bnd_x = 12'(nx) * 12'(s);
  assign bnd_y = 12'(ny) * 12'(s);
  assign bnd_z = 12'(nz) * 12'(s);
  assign bad   = {5'b0, cx_q} >= bnd_x || {5'b0, cy_q} >= bnd_y || {5'b0, cz_q} >= bnd_z;
  assign wr_ok = coord_x_i < nx && coord_y_i < ny && coord_z_i < nz;

  // divider: coordinate split, then weights
  logic [CW-1:0] ix_q, iy_q, iz_q, ccur;
  logic [SW-1:0] dcur_q, e;
  logic [8:0]    e2_q, de_q, d2_q, ss_q;
  logic [13:0]   n_q [4];
  logic [13:0]   den_q, s3;
  logic [9:0]    mid1, mid2;
  logic [ptu_pkg::DIV_NW-1:0] div_num, wnum;
  logic [ptu_pkg::DIV_DW-1:0] div_den, div_rem;
  logic [ptu_pkg::DIV_QW-1:0] div_quo;
  logic          div_busy, div_done;
  logic signed [WW-1:0] wx_q [4], wy_q [4], wz_q [4], wnew;

  always_comb begin
    case (cmd_i.axis)
      ptu_pkg::AXIS_X: ccur = cx_q;
      ptu_pkg::AXIS_Y: ccur = cy_q;
      default:         ccur = cz_q;
    endcase
  end

  assign wnum    = {1'b0, n_q[cmd_i.wk], 16'b0} + {17'b0, den_q[13:1]};
  assign div_num = cmd_i.div_wgt ? wnum : {{(ptu_pkg::DIV_NW-CW){1'b0}}, ccur};
  assign div_den = cmd_i.div_wgt ? den_q : {{(ptu_pkg::DIV_DW-SW){1'b0}}, s};

  ptu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign e    = s - dcur_q;
  assign mid1 = {e2_q, 1'b0} + 10'(de_q) * 10'd6 + {1'b0, d2_q};
  assign mid2 = {1'b0, e2_q} + 10'(de_q) * 10'd6 + {d2_q, 1'b0};
  assign s3   = 14'(ss_q) * 14'(s);
  // first and last taps are non-positive
  assign wnew = (cmd_i.wk == 2'd0 || cmd_i.wk == 2'd3) ? -$signed({1'b0, div_quo})
                                                       : $signed({1'b0, div_quo});

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_coord) begin
      dcur_q <= div_rem[SW-1:0];
      case (cmd_i.axis)
        ptu_pkg::AXIS_X: ix_q <= div_quo[CW-1:0];
        ptu_pkg::AXIS_Y: iy_q <= div_quo[CW-1:0];
        default:         iz_q <= div_quo[CW-1:0];
      endcase
    end
    if (cmd_i.num1) begin
      e2_q <= 9'(e) * 9'(e);
      de_q <= 9'(dcur_q) * 9'(e);
      d2_q <= 9'(dcur_q) * 9'(dcur_q);
      ss_q <= 9'(s) * 9'(s);
    end
    if (cmd_i.num2) begin
      n_q[0] <= 14'(dcur_q) * 14'(e2_q);
      n_q[1] <= 14'(mid1) * 14'(e);
      n_q[2] <= 14'(mid2) * 14'(dcur_q);
      n_q[3] <= 14'(d2_q) * 14'(e);
      den_q  <= {s3[12:0], 1'b0};
    end
    if (cmd_i.store_weight) begin
      case (cmd_i.axis)
        ptu_pkg::AXIS_X: wx_q[cmd_i.wk] <= wnew;
        ptu_pkg::AXIS_Y: wy_q[cmd_i.wk] <= wnew;
        default:         wz_q[cmd_i.wk] <= wnew;
      endcase
    end
  end

  // memory port: writes in idle, neighborhood reads during a query
  logic [CW-1:0] gx, gy, gz;
  assign gx = ptu_pkg::wrap_idx(ix_q, cmd_i.p, nx);
  assign gy = ptu_pkg::wrap_idx(iy_q, cmd_i.o, ny);
  assign gz = ptu_pkg::wrap_idx(iz_q, cmd_i.q, nz);

  assign ram_we_o    = cmd_i.wr_req && wr_ok;
  assign ram_wdata_o = sample_value_i;
  assign ram_addr_o  = cmd_i.wr_req
      ? {coord_z_i[AXW-1:0], coord_y_i[AXW-1:0], coord_x_i[AXW-1:0]}
      : {gz[AXW-1:0], gy[AXW-1:0], gx[AXW-1:0]};

  // MAC pipeline: issue -> operand select/multiply -> accumulate
  logic            s1_v_q, s2_v_q;
  ptu_pkg::op_e    s1_op_q, s2_op_q;
  logic [1:0]      s1_idx_q;
  logic signed [39:0] ma;
  logic signed [WW-1:0] mb;
  logic signed [57:0] prod_q;
  logic signed [51:0] zsum_q, zinc;
  logic signed [55:0] ysum_q, yinc;
  logic signed [59:0] acc_q, ainc;
  logic signed [35:0] zr;
  logic signed [39:0] yr;
  logic signed [43:0] fr;
  logic signed [31:0] sat;

  assign zinc = zsum_q + 52'sd32768;
  assign zr   = zinc[51:16];
  assign yinc = ysum_q + 56'sd32768;
  assign yr   = yinc[55:16];
  assign ainc = acc_q + 60'sd32768;
  assign fr   = ainc[59:16];

  always_comb begin
    case (s1_op_q)
      ptu_pkg::OP_Z: begin
        ma = {{8{ram_rdata_i[31]}}, ram_rdata_i};
        mb = wz_q[s1_idx_q];
      end
      ptu_pkg::OP_Y: begin
        ma = {{4{zr[35]}}, zr};
        mb = wy_q[s1_idx_q];
      end
      ptu_pkg::OP_X: begin
        ma = yr;
        mb = wx_q[s1_idx_q];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.op_valid;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q <= cmd_i.op;
    case (cmd_i.op)
      ptu_pkg::OP_Z: s1_idx_q <= cmd_i.q;
      ptu_pkg::OP_Y: s1_idx_q <= cmd_i.o;
      default:       s1_idx_q <= cmd_i.p;
    endcase
    s2_op_q <= s1_op_q;
    prod_q  <= ma * mb;

    // an axis sum is cleared as it is handed on to the next stage
    if (cmd_i.clr_acc || (s1_v_q && s1_op_q == ptu_pkg::OP_Y)) zsum_q <= '0;
    else if (s2_v_q && s2_op_q == ptu_pkg::OP_Z) zsum_q <= zsum_q + $signed(prod_q[51:0]);

    if (cmd_i.clr_acc || (s1_v_q && s1_op_q == ptu_pkg::OP_X)) ysum_q <= '0;
    else if (s2_v_q && s2_op_q == ptu_pkg::OP_Y) ysum_q <= ysum_q + $signed(prod_q[55:0]);

    if (cmd_i.clr_acc) acc_q <= '0;
    else if (s2_v_q && s2_op_q == ptu_pkg::OP_X) acc_q <= acc_q + {{2{prod_q[57]}}, prod_q};
  end

  always_comb begin
    if (fr > 44'sd2147483647) sat = 32'sh7fffffff;
    else if (fr < -44'sd2147483648) sat = 32'sh80000000;
    else sat = fr[31:0];
  end

  // result register
  logic               out_valid_q;
  logic signed [31:0] out_val_q;
  logic               out_stat_q;
  logic               out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_val_q  <= bad ? 32'sd0 : sat;
      out_stat_q <= bad;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign interpolated_value_o = out_val_q;
  assign query_status_o       = out_stat_q;

  assign sts_o.div_busy  = div_busy;
  assign sts_o.div_done  = div_done;
  assign sts_o.bad_query = bad;
  assign sts_o.out_free  = out_free;
endmodule
`default_nettype wire

// ===== design/periodic_tricubic_upsampler_top.sv =====
// Channel  Handshake                Payload
// in       in_valid_i / in_stall_o  func, coord_x/y/z, sample_value
// out      out_valid_o / out_stall_i interpolated_value, query_status
// cfg      cfg_valid_i / cfg_ready_o cfg_index, cfg_data
//
// Write: stored straight into the single-port grid RAM when inside the grid.
// Query out of range: answered with a zero value and status set. In range: paced by the
// shared radix-2 divider (15 divisions for offsets and weights) and by the 64
// neighborhood reads through the one RAM port.
// Reset clears control and restores the default configuration; grid contents are undefined until written.
// A waiting result holds the next query in its final state until taken.
`default_nettype none
module periodic_tricubic_upsampler_top #(
  parameter int MAX_AXIS  = 16,
  parameter int MAX_SCALE = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic [6:0]         coord_x_i,
  input  wire logic [6:0]         coord_y_i,
  input  wire logic [6:0]         coord_z_i,
  input  wire logic signed [31:0] sample_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      interpolated_value_o,
  output logic                    query_status_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [4:0]         cfg_data_i
);
  localparam int AXW   = (MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 1;
  localparam int AW    = 3 * AXW;
  localparam int DEPTH = 2 ** AW;

  ptu_pkg::cmd_t cmd;
  ptu_pkg::sts_t sts;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  ptu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ptu_datapath #(
    .MAX_AXIS  (MAX_AXIS),
    .MAX_SCALE (MAX_SCALE),
    .AXW       (AXW),
    .AW        (AW)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .coord_x_i            (coord_x_i),
    .coord_y_i            (coord_y_i),
    .coord_z_i            (coord_z_i),
    .sample_value_i       (sample_value_i),
    .cfg_we_i             (cfg_valid_i && cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .ram_we_o             (ram_we),
    .ram_addr_o           (ram_addr),
    .ram_wdata_o          (ram_wdata),
    .ram_rdata_i          (ram_rdata),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .interpolated_value_o (interpolated_value_o),
    .query_status_o       (query_status_o)
  );

  ptu_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_AXIS = 16;
  localparam int SCALE_MAX = 8;
  localparam int ITEM_GOAL = 1400;
  localparam int CALM_FROM = 1250;
  localparam int DRAIN_WAIT = 500;
  localparam int HOLD_CYCLES = 2000;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct {
    logic signed [31:0] value;
    logic               status;
  } interp_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [4:0]  data;
    logic        fn;
    logic [6:0]  x;
    logic [6:0]  y;
    logic [6:0]  z;
    logic [31:0] v;
    bit          typed;
    logic [31:0] ev;
    logic        es;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, func_i;
  logic [6:0] coord_x_i, coord_y_i, coord_z_i;
  logic signed [31:0] sample_value_i;
  logic out_valid_o, out_stall_i, query_status_o;
  logic signed [31:0] interpolated_value_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [4:0] cfg_data_i;

  periodic_tricubic_upsampler_top i_dut (.*);

  // shadow copy of grid and registers
  logic signed [31:0] grid_mem [GRID_AXIS*GRID_AXIS*GRID_AXIS];
  bit                 written [GRID_AXIS*GRID_AXIS*GRID_AXIS];
  logic [4:0] size_x, size_y, size_z;
  logic [3:0] scale;

  interp_t pending_q[$];
  row_t    dir_rows[$];
  int errors, items, queries, checked, settings;
  bit calm, hold_req;
  longint cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic int clamp_eff(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Catmull-Rom tap k for offset d, rounded to Q2.16 half away from zero
  function automatic longint cr_weight(int s, int d, int k);
    longint e, num, den, mag, r;
    e = s - d;
    den = 2 * s * s * s;
    case (k)
      0: num = -d * e * e;
      1: num = (2 * e * e + 6 * d * e + d * d) * e;
      2: num = (e * e + 6 * d * e + 2 * d * d) * d;
      default: num = -d * d * e;
    endcase
    mag = (num < 0) ? -num : num;
    r = (mag * 65536 + den / 2) / den;
    return (num < 0) ? -r : r;
  endfunction

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic int grid_addr(int x, int y, int z);
    return (z * GRID_AXIS + y) * GRID_AXIS + x;
  endfunction

  function automatic void queue_row(input row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic interp_t interp_point(int x, int y, int z);
    interp_t r;
    int nx, ny, nz, s, gx, gy, gz;
    longint zsum, ysum, acc;
    nx = clamp_eff(size_x, GRID_AXIS);
    ny = clamp_eff(size_y, GRID_AXIS);
    nz = clamp_eff(size_z, GRID_AXIS);
    s = clamp_eff(scale, SCALE_MAX);
    if (x >= nx * s || y >= ny * s || z >= nz * s) begin
      r.value = '0;
      r.status = 1'b1;
      return r;
    end
    acc = 0;
    for (int p = 0; p < 4; p++) begin
      gx = (x / s + nx - 1 + p) % nx;
      ysum = 0;
      for (int o = 0; o < 4; o++) begin
        gy = (y / s + ny - 1 + o) % ny;
        zsum = 0;
        for (int q = 0; q < 4; q++) begin
          gz = (z / s + nz - 1 + q) % nz;
          zsum += cr_weight(s, z % s, q) * longint'(grid_mem[grid_addr(gx, gy, gz)]);
        end
        ysum += cr_weight(s, y % s, o) * rnd16(zsum);
      end
      acc += cr_weight(s, x % s, p) * rnd16(ysum);
    end
    acc = rnd16(acc);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    r.value = acc[31:0];
    r.status = 1'b0;
    return r;
  endfunction

  task automatic send_item(input logic fn, input int x, input int y, input int z,
                           input logic [31:0] v, input bit typed, input interp_t tv);
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i = fn;
    coord_x_i = x[6:0];
    coord_y_i = y[6:0];
    coord_z_i = z[6:0];
    sample_value_i = v;
    do @(posedge clk_i); while (in_stall_o);
    items++;
    if (fn == ptu_pkg::FUNC_QUERY) begin
      pending_q.insert(pending_q.size(), typed ? tv : interp_point(x, y, z));
      queries++;
    end else if (x < clamp_eff(size_x, GRID_AXIS) && y < clamp_eff(size_y, GRID_AXIS) &&
                 z < clamp_eff(size_z, GRID_AXIS)) begin
      grid_mem[grid_addr(x, y, z)] = v;
      written[grid_addr(x, y, z)] = 1'b1;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ptu_pkg::CFG_GRID_X: size_x = data;
      ptu_pkg::CFG_GRID_Y: size_y = data;
      ptu_pkg::CFG_GRID_Z: size_z = data;
      default:             scale = data[3:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    interp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: value %0d status %0d",
               interpolated_value_o, query_status_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        checked++;
        if (interpolated_value_o !== e.value) begin
          $error("interpolated_value: expected %0d, got %0d", e.value, interpolated_value_o);
          errors++;
        end
        if (query_status_o !== e.status) begin
          $error("query_status: expected %0d, got %0d", e.status, query_status_o);
          errors++;
        end
      end
    end
  end

  initial begin
    interp_t none;
    int nx, ny, nz, s, pick;
    logic [31:0] v;
    logic [4:0] preset [6][4];

    none = '{value: '0, status: 1'b0};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = ptu_pkg::FUNC_WRITE;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    sample_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = ptu_pkg::CFG_GRID_X;
    cfg_data_i = '0;
    size_x = 5'd16;
    size_y = 5'd16;
    size_z = 5'd16;
    scale = 4'd2;
    hold_req = 1'b0;
    calm = 1'b0;
    preset = '{'{5'd16, 5'd1, 5'd1, 5'd3}, '{5'd1, 5'd16, 5'd1, 5'd8},
               '{5'd1, 5'd1, 5'd16, 5'd1}, '{5'd0, 5'd31, 5'd2, 5'd0},
               '{5'd16, 5'd16, 5'd1, 5'd15}, '{5'd3, 5'd2, 5'd4, 5'd21}};

    // defaults: range checks; then single-point grid with extremes
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 32, 0, 0, 0, 1, 0, 1});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 0, 127, 0, 0, 1, 0, 1});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 0, 0, 32, 0, 1, 0, 1});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 127, 127, 127, 0, 1, 0, 1});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_WRITE, 16, 0, 0, 32'h1234, 0, 0, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_WRITE, 0, 0, 127, 32'hffffffff, 0, 0, 0});
    queue_row('{1, ptu_pkg::CFG_GRID_X, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    queue_row('{1, ptu_pkg::CFG_GRID_Y, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    queue_row('{1, ptu_pkg::CFG_GRID_Z, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    queue_row('{1, ptu_pkg::CFG_SCALE, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_WRITE, 0, 0, 0, 32'h7fffffff, 0, 0, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, 32'h7fffffff, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 1, 0, 0, 0, 1, 0, 1});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_WRITE, 0, 0, 0, 32'h80000000, 0, 0, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, 32'h80000000, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_WRITE, 0, 0, 0, 32'h00010000, 0, 0, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, 32'h00010000, 0});
    // zero x size and zero factor act as one
    queue_row('{1, ptu_pkg::CFG_GRID_X, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    queue_row('{1, ptu_pkg::CFG_SCALE, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, 32'h00010000, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 0, 1, 0, 0, 1, 0, 1});
    // factor above max acts as max
    queue_row('{1, ptu_pkg::CFG_SCALE, 15, 0, 0, 0, 0, 0, 0, 0, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 7, 7, 7, 0, 0, 0, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 3, 5, 1, 0, 0, 0, 0});
    queue_row('{0, 0, 0, ptu_pkg::FUNC_QUERY, 8, 0, 0, 0, 1, 0, 1});

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].fn, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                  dir_rows[i].v, dir_rows[i].typed,
                  '{value: dir_rows[i].ev, status: dir_rows[i].es});
      end
    end

    while (items < ITEM_GOAL) begin
      wait_drained();
      if (settings < 6) begin
        for (int k = 0; k < 4; k++) write_reg(2'(k), preset[settings][k]);
      end else begin
        write_reg(ptu_pkg::CFG_GRID_X, 5'($urandom_range(1, 5)));
        write_reg(ptu_pkg::CFG_GRID_Y, 5'($urandom_range(1, 5)));
        write_reg(ptu_pkg::CFG_GRID_Z, 5'($urandom_range(1, 5)));
        write_reg(ptu_pkg::CFG_SCALE, 5'($urandom_range(0, 31)));
      end
      settings++;
      calm = (items > CALM_FROM);
      nx = clamp_eff(size_x, GRID_AXIS);
      ny = clamp_eff(size_y, GRID_AXIS);
      nz = clamp_eff(size_z, GRID_AXIS);
      s = clamp_eff(scale, SCALE_MAX);

      // fill any entry the new grid can reach that still holds nothing
      for (int z = 0; z < nz; z++)
        for (int y = 0; y < ny; y++)
          for (int x = 0; x < nx; x++)
            if (!written[grid_addr(x, y, z)])
              send_item(ptu_pkg::FUNC_WRITE, x, y, z, $urandom, 0, none);

      if (settings == 3) hold_req = 1'b1;
      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 99);
        v = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000)
                                         : $urandom;
        if (pick < 70)
          send_item(ptu_pkg::FUNC_QUERY, $urandom_range(0, nx * s - 1),
                    $urandom_range(0, ny * s - 1), $urandom_range(0, nz * s - 1),
                    $urandom, 0, none);
        else if (pick < 80)
          send_item(ptu_pkg::FUNC_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 127), $urandom, 0, none);
        else if (pick < 95)
          send_item(ptu_pkg::FUNC_WRITE, $urandom_range(0, nx - 1), $urandom_range(0, ny - 1),
                    $urandom_range(0, nz - 1), v, 0, none);
        else
          send_item(ptu_pkg::FUNC_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 127), v, 0, none);
      end
    end

    wait_drained();
    $display("tb: %0d items sent, %0d queries, %0d results checked", items, queries, checked);
    $display("tb: %0d register settings incl. zero, oversize and max sizes/factors", settings);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
